@@ hw/rtl/cluster_chain_table_engine_macros.svh @@
// Assertion macros shared by the checker of the cluster chain table engine.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef CLUSTER_CHAIN_TABLE_ENGINE_MACROS_SVH
`define CLUSTER_CHAIN_TABLE_ENGINE_MACROS_SVH

// The consequent must hold at the same edge as the antecedent.
`define CCTE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: %m");

// The consequent must hold at the edge after the antecedent.
`define CCTE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: %m");

`endif

@@ hw/rtl/ccte_pkg.sv @@
// Package of the cluster chain table engine: codes, widths, defaults, types.
// No dependencies; the top level, the sequencer and the checker use it.
`default_nettype none

package ccte_pkg;

	localparam int MAP_DEPTH_DEF = 256;
	localparam int MAX_HOPS_DEF  = 255;

	localparam int ENTRY_W = 8;
	localparam int SIZE_W  = 19;

	// Operation codes of an input item.
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_HEADER = 2'd1;
	localparam logic [1:0] OP_FREE   = 2'd2;
	localparam logic [1:0] OP_SIZE   = 2'd3;

	// Status codes of a result item.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_CHAIN = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SECTOR_SIZE  = 2'd0;
	localparam logic [1:0] CFG_CLU_SECTORS  = 2'd1;
	localparam logic [1:0] CFG_LAST_CLUSTER = 2'd2;
	localparam logic [1:0] CFG_RESERVED     = 2'd3;

	// Entries below this value end a chain; clusters below it are never freed.
	localparam logic [7:0] FIRST_DATA_CLUSTER = 8'h08;

	typedef struct packed {
		logic       sector_size_256;
		logic [2:0] cluster_sectors;
		logic [7:0] last_cluster;
		logic [7:0] reserved_cluster;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		sector_size_256:  1'b0,
		cluster_sectors:  3'd6,
		last_cluster:     8'd127,
		reserved_cluster: 8'd66
	};

endpackage

`default_nettype wire

@@ hw/rtl/ccte_if.sv @@
// Handshake interfaces of the cluster chain table engine: command and response.
// Depends on nothing but plain logic types.
`default_nettype none

interface ccte_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] cluster;
	logic [7:0] entry_value;
	logic [7:0] last_byte_index;

	modport source (output valid, operation, cluster, entry_value, last_byte_index,
		input ready);
	modport sink (input valid, operation, cluster, entry_value, last_byte_index,
		output ready);
	modport mon (input valid, ready, operation, cluster, entry_value, last_byte_index);
endinterface

interface ccte_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [18:0] file_size;
	logic [7:0]  free_total;
	logic [7:0]  free_head;

	modport source (output valid, status, file_size, free_total, free_head, input ready);
	modport sink (input valid, status, file_size, free_total, free_head, output ready);
	modport mon (input valid, ready, status, file_size, free_total, free_head);
endinterface

`default_nettype wire

@@ hw/rtl/cluster_chain_table_engine.sv @@
// Top level of the cluster chain table engine: configuration registers,
// cluster map RAM and sequencer. Depends on ccte_pkg, ccte_if, ccte_ram, ccte_ctrl.
//
//   Channel  Direction  Handshake      Payload
//   cmd      in         valid/ready    operation, cluster, entry_value, last_byte_index
//   rsp      out        valid/ready    status, file_size, free_total, free_head
//   cfg      in         cfg_we         cfg_index, cfg_data (no back-pressure)
//
// One item is worked on at a time. Load, set-header, a rejected free and a free at
// the head go straight to the result; a free that walks the chain reads links until
// it links the cluster in or finds a bad chain, and a file-size walk reads links
// until the chain ends or the hop limit is hit. Walks are paced by the single read
// port of the map RAM, which yields one chain link per cycle.
// Reset clears the head and the count and returns the configuration to its defaults;
// the map is not cleared.
// A result waits in an output register, so the next item is taken while it stalls.
`default_nettype none

module cluster_chain_table_engine #(
	parameter int MAP_DEPTH = ccte_pkg::MAP_DEPTH_DEF,
	parameter int MAX_HOPS  = ccte_pkg::MAX_HOPS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	ccte_cmd_if.sink        cmd,
	ccte_rsp_if.source      rsp
);

	localparam int AW = $clog2(MAP_DEPTH);

	ccte_pkg::cfg_t cfg_q;

	logic                          map_rd_en;
	logic [AW-1:0]                 map_rd_addr;
	logic [ccte_pkg::ENTRY_W-1:0]  map_rd_data;
	logic                          map_wr_en;
	logic [AW-1:0]                 map_wr_addr;
	logic [ccte_pkg::ENTRY_W-1:0]  map_wr_data;

	// Configuration registers. The user must make writes only while the engine is idle;
	// the block does not enforce it. The sequencer then sees them as constants during an item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ccte_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ccte_pkg::CFG_SECTOR_SIZE: begin
					cfg_q.sector_size_256 <= cfg_data[0];
				end
				ccte_pkg::CFG_CLU_SECTORS: begin
					cfg_q.cluster_sectors <= cfg_data[2:0];
				end
				ccte_pkg::CFG_LAST_CLUSTER: begin
					cfg_q.last_cluster <= cfg_data;
				end
				ccte_pkg::CFG_RESERVED: begin
					cfg_q.reserved_cluster <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// The cluster map. Its contents are undefined until loaded. Each item finishes
	// its writes before the next item issues its first read; a load reads and writes
	// its own entry in the same cycle, but that read data is not used.
	ccte_ram #(
		.WIDTH(ccte_pkg::ENTRY_W),
		.DEPTH(MAP_DEPTH)
	) u_map (
		.clk    (clk),
		.wr_en  (map_wr_en),
		.wr_addr(map_wr_addr),
		.wr_data(map_wr_data),
		.rd_en  (map_rd_en),
		.rd_addr(map_rd_addr),
		.rd_data(map_rd_data)
	);

	// Sequencer: free-list head and count, chain walks and the output register.
	ccte_ctrl #(
		.MAP_DEPTH(MAP_DEPTH),
		.MAX_HOPS (MAX_HOPS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.rsp        (rsp),
		.map_rd_en  (map_rd_en),
		.map_rd_addr(map_rd_addr),
		.map_rd_data(map_rd_data),
		.map_wr_en  (map_wr_en),
		.map_wr_addr(map_wr_addr),
		.map_wr_data(map_wr_data)
	);

endmodule

`default_nettype wire

@@ hw/rtl/ccte_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
`default_nettype none

module ccte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ccte_ctrl.sv @@
// Sequencer of the cluster chain table engine: free list, chain walks, results.
// Depends on ccte_pkg and the interfaces in ccte_if.sv; drives the map RAM.
`default_nettype none

module ccte_ctrl #(
	parameter int MAP_DEPTH = ccte_pkg::MAP_DEPTH_DEF,
	parameter int MAX_HOPS  = ccte_pkg::MAX_HOPS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ccte_pkg::cfg_t               cfg,
	ccte_cmd_if.sink                          cmd,
	ccte_rsp_if.source                        rsp,
	output logic                              map_rd_en,
	output logic [$clog2(MAP_DEPTH)-1:0]      map_rd_addr,
	input  wire logic [ccte_pkg::ENTRY_W-1:0] map_rd_data,
	output logic                              map_wr_en,
	output logic [$clog2(MAP_DEPTH)-1:0]      map_wr_addr,
	output logic [ccte_pkg::ENTRY_W-1:0]      map_wr_data
);

	localparam int AW = $clog2(MAP_DEPTH);
	localparam int HW = $clog2(MAX_HOPS);
	localparam logic [8:0] DEPTH9 = 9'(MAP_DEPTH);
	localparam logic [HW-1:0] LAST_HOP = HW'(MAX_HOPS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FREE_WALK,
		S_FREE_LINK,
		S_SIZE_WALK,
		S_RESP
	} state_t;

	state_t      state_q;
	logic [7:0]  cl_q;
	logic [7:0]  lb_q;
	logic [7:0]  link_q;
	logic        oor_q;
	logic [HW-1:0] hops_q;
	logic [18:0] acc_q;
	logic [7:0]  head_q;
	logic [7:0]  count_q;
	logic [1:0]  res_status_q;
	logic [18:0] res_size_q;
	logic        rsp_valid_q;
	logic [1:0]  rsp_status_q;
	logic [18:0] rsp_size_q;
	logic [7:0]  rsp_total_q;
	logic [7:0]  rsp_head_q;

	logic        cmd_acc;
	logic [7:0]  rd_val;
	logic [7:0]  rd_idx;
	logic [8:0]  res_plus1;
	logic        range_bad;
	logic        cont_walk;
	logic        ins_ok;
	logic [10:0] clu_bytes;
	logic [10:0] tail_bytes;
	logic [18:0] final_size;

	// An index beyond the map reads as zero.
	assign rd_val  = oor_q ? '0 : map_rd_data;
	assign cmd_acc = cmd.valid && (state_q == S_IDLE);
	assign cmd.ready = (state_q == S_IDLE);

	assign res_plus1 = {1'b0, cfg.reserved_cluster} + 9'd1;
	assign range_bad = (cmd.cluster > cfg.last_cluster)
		|| (cmd.cluster < ccte_pkg::FIRST_DATA_CLUSTER)
		|| (cmd.cluster == ccte_pkg::FIRST_DATA_CLUSTER && cfg.sector_size_256)
		|| (cmd.cluster == cfg.reserved_cluster)
		|| ({1'b0, cmd.cluster} == res_plus1);

	assign cont_walk = (rd_val > link_q) && (rd_val < cl_q);
	assign ins_ok    = (rd_val > cl_q) || (rd_val == 8'd0);

	assign clu_bytes  = cfg.sector_size_256 ? {cfg.cluster_sectors, 8'd0}
		: {1'b0, cfg.cluster_sectors, 7'd0};
	assign tail_bytes = cfg.sector_size_256 ? {rd_val[2:0], 8'd0}
		: {1'b0, rd_val[2:0], 7'd0};
	assign final_size = acc_q + 19'(tail_bytes) + 19'(lb_q) + 19'd1;

	// Map read address: during a walk the link being examined is the next read address.
	always_comb begin
		rd_idx    = rd_val;
		map_rd_en = 1'b0;
		case (state_q)
			S_IDLE: begin
				rd_idx    = (cmd.operation == ccte_pkg::OP_FREE) ? head_q : cmd.cluster;
				map_rd_en = cmd_acc;
			end
			S_FREE_WALK, S_SIZE_WALK: begin
				map_rd_en = 1'b1;
			end
			default: begin
				map_rd_en = 1'b0;
			end
		endcase
	end
	assign map_rd_addr = rd_idx[AW-1:0];

	// Map write port; writes beyond the map are dropped.
	always_comb begin
		map_wr_en   = 1'b0;
		map_wr_addr = cl_q[AW-1:0];
		map_wr_data = rd_val;
		case (state_q)
			S_IDLE: begin
				map_wr_addr = cmd.cluster[AW-1:0];
				if (cmd.operation == ccte_pkg::OP_LOAD) begin
					map_wr_data = cmd.entry_value;
					map_wr_en   = cmd_acc && ({1'b0, cmd.cluster} < DEPTH9);
				end else begin
					map_wr_data = head_q;
					map_wr_en   = cmd_acc && (cmd.operation == ccte_pkg::OP_FREE)
						&& !range_bad && (head_q == 8'd0 || head_q > cmd.cluster)
						&& ({1'b0, cmd.cluster} < DEPTH9);
				end
			end
			S_FREE_WALK: begin
				map_wr_en = !cont_walk && ins_ok && ({1'b0, cl_q} < DEPTH9);
			end
			S_FREE_LINK: begin
				map_wr_addr = link_q[AW-1:0];
				map_wr_data = cl_q;
				map_wr_en   = ({1'b0, link_q} < DEPTH9);
			end
			default: begin
				map_wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			oor_q       <= 1'b0;
		end else begin
			if (map_rd_en) begin
				oor_q <= !({1'b0, rd_idx} < DEPTH9);
			end
			// In S_RESP the output register is reloaded below instead.
			if (rsp_valid_q && rsp.ready && state_q != S_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						cl_q         <= cmd.cluster;
						lb_q         <= cmd.last_byte_index;
						res_size_q   <= '0;
						link_q       <= head_q;
						hops_q       <= '0;
						acc_q        <= '0;
						case (cmd.operation)
							ccte_pkg::OP_HEADER: begin
								head_q       <= cmd.cluster;
								count_q      <= cmd.entry_value;
								res_status_q <= ccte_pkg::ST_OK;
								state_q      <= S_RESP;
							end
							ccte_pkg::OP_FREE: begin
								if (range_bad) begin
									res_status_q <= ccte_pkg::ST_RANGE;
									state_q      <= S_RESP;
								end else if (head_q == 8'd0 || head_q > cmd.cluster) begin
									head_q       <= cmd.cluster;
									count_q      <= count_q + 8'd1;
									res_status_q <= ccte_pkg::ST_OK;
									state_q      <= S_RESP;
								end else if (head_q == cmd.cluster) begin
									res_status_q <= ccte_pkg::ST_CHAIN;
									state_q      <= S_RESP;
								end else begin
									res_status_q <= ccte_pkg::ST_OK;
									state_q      <= S_FREE_WALK;
								end
							end
							ccte_pkg::OP_SIZE: begin
								res_status_q <= ccte_pkg::ST_OK;
								state_q      <= S_SIZE_WALK;
							end
							default: begin
								res_status_q <= ccte_pkg::ST_OK;
								state_q      <= S_RESP;
							end
						endcase
					end
				end
				S_FREE_WALK: begin
					if (cont_walk) begin
						link_q <= rd_val;
					end else if (ins_ok) begin
						state_q <= S_FREE_LINK;
					end else begin
						res_status_q <= ccte_pkg::ST_CHAIN;
						state_q      <= S_RESP;
					end
				end
				S_FREE_LINK: begin
					count_q <= count_q + 8'd1;
					state_q <= S_RESP;
				end
				S_SIZE_WALK: begin
					if (rd_val < ccte_pkg::FIRST_DATA_CLUSTER) begin
						res_size_q <= final_size;
						state_q    <= S_RESP;
					end else if (rd_val > cfg.last_cluster || hops_q == LAST_HOP) begin
						res_status_q <= ccte_pkg::ST_CHAIN;
						state_q      <= S_RESP;
					end else begin
						hops_q <= hops_q + HW'(1);
						acc_q  <= acc_q + 19'(clu_bytes);
					end
				end
				S_RESP: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_size_q   <= res_size_q;
						rsp_total_q  <= count_q;
						rsp_head_q   <= head_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.file_size  = rsp_size_q;
	assign rsp.free_total = rsp_total_q;
	assign rsp.free_head  = rsp_head_q;

endmodule

`default_nettype wire

@@ hw/rtl/ccte_checker.sv @@
// Port-level checker of the cluster chain table engine, bound to the top level.
// Depends on ccte_pkg and the assertion macro header.
`default_nettype none
`include "cluster_chain_table_engine_macros.svh"

module ccte_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_valid,
	input wire logic        cmd_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [1:0]  rsp_status,
	input wire logic [18:0] rsp_file_size,
	input wire logic [36:0] rsp_payload
);

	// A stalled result keeps its contents.
	`CCTE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

	// The engine works on one item at a time: it is busy right after taking one.
	`CCTE_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready)

	// A new result appears only as the engine returns to idle.
	`CCTE_ASSERT_SAME(a_result_at_idle, $rose(rsp_valid), cmd_ready)

	// Only a successful file-size walk reports a length.
	`CCTE_ASSERT_SAME(a_size_only_ok, rsp_valid && rsp_status != ccte_pkg::ST_OK, rsp_file_size == 19'd0)

endmodule

bind cluster_chain_table_engine ccte_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_file_size(rsp.file_size),
	.rsp_payload  ({rsp.status, rsp.file_size, rsp.free_total, rsp.free_head})
);

`default_nettype wire
